@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge while out of reset
`define EAS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define EAS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/eas_pkg.sv @@
// package of the encoder angle and speed estimator: types, codes and helpers
package eas_pkg;

    localparam int PPR_LOG2_DEFAULT = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN = -24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLE_PAIRS    = 3'd0,
        REG_COUNTER_PER   = 3'd1,
        REG_WRAP_THRESH   = 3'd2,
        REG_SPEED_SCALE   = 3'd3,
        REG_GAIN_NEW      = 3'd4,
        REG_GAIN_OLD      = 3'd5,
        REG_SPEED_DECIM   = 3'd6
    } eas_reg_idx_t;

    typedef struct packed {
        logic [6:0]  pole_pairs;
        logic [15:0] counter_period;
        logic [14:0] wrap_threshold;
        logic [15:0] speed_scale;
        logic [15:0] filter_gain_new;
        logic [15:0] filter_gain_old;
        logic [7:0]  speed_decimation;
    } eas_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_DIFF,
        ST_RAW,
        ST_RAW_SAT,
        ST_ACC_NEW,
        ST_ACC_OLD,
        ST_FILT,
        ST_ELEC,
        ST_DONE
    } eas_state_t;

    // clamp a wide signed value to 24 bits signed
    function automatic logic signed [23:0] sat_s24(input logic signed [43:0] v);
        logic signed [23:0] r;
        if (v > 44'(S24_MAX))
            r = S24_MAX;
        else if (v < 44'(S24_MIN))
            r = S24_MIN;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

@@ hdl/encoder_angle_speed_estimator_core.sv @@
// top level of the encoder angle and speed estimator
// Takes one encoder counter value per beat on the s_ side and returns one result beat on the
// m_ side: mechanical and electrical angle as 16-bit fractions of a turn, the filtered
// mechanical speed (24 bit signed) and that speed times pole pairs (32 bit signed), plus a
// flag in m_tuser that marks ticks where the speed was recomputed (every speed_decimation-th
// tick, or every tick when speed_decimation is 0). All products go through one shared
// 25x18 signed multiplier under a small sequencer, which goes through the extra speed
// update steps only on ticks that recompute the speed; s_tready is high only while
// the sequencer is idle. A finished result sits in an output register, so the next beat is
// taken while the previous result waits for m_tready. Configuration writes go to the plain
// write port and must only happen while the block is idle.
module encoder_angle_speed_estimator_core
    import eas_pkg::*;
#(
    parameter int PULSES_PER_REV_LOG2 = PPR_LOG2_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] encoder_count
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // [15:0] mech_angle, [31:16] elec_angle,
                                             // [55:32] mech_speed, [87:56] elec_speed
    output logic [0:0]            m_tuser,   // [0] speed_updated
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AngShift = 16 - PULSES_PER_REV_LOG2;

    eas_cfg_t cfg;

    // sequencer
    eas_state_t state_reg, state_next;

    // speed state
    logic [15:0]        last_count_reg;
    logic [7:0]         tick_reg;
    logic signed [23:0] filt_reg;

    // per-beat working registers
    logic [15:0]        count_reg;
    logic [15:0]        elec_ang_reg;
    logic signed [17:0] d_reg;
    logic signed [23:0] raw_reg;
    logic signed [42:0] acc_reg;
    logic               upd_reg;

    // output register
    logic               out_valid_reg;
    logic [87:0]        out_data_reg;
    logic               out_upd_reg;

    // shared multiplier
    logic               mul_en;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;

    // difference and wrap correction
    logic [15:0]        diff_u;
    logic signed [17:0] d_raw;
    logic signed [17:0] thr;
    logic signed [17:0] period;
    logic signed [17:0] d_wrap;
    logic [7:0]         tick_inc;
    logic               do_update;

    logic               s_fire;
    logic               out_load;
    logic [15:0]        mech_frac;
    logic [15:0]        elec_frac;
    logic signed [43:0] filt_sum;

    eas_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    eas_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    // result may land once the previous one has gone or goes this cycle
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // signed 16-bit difference since the last speed update
    assign diff_u   = count_reg - last_count_reg;
    assign d_raw    = 18'(signed'(diff_u));
    assign thr      = signed'({3'b000, cfg.wrap_threshold});
    assign period   = signed'({2'b00, cfg.counter_period});
    assign tick_inc = tick_reg + 8'd1;
    assign do_update = (tick_inc >= cfg.speed_decimation);

    always_comb
    begin
        if (d_raw > thr)
            d_wrap = d_raw - period;
        else if (d_raw < -thr)
            d_wrap = d_raw + period;
        else
            d_wrap = d_raw;
    end

    // angles: low bits of the count, moved up to a 16-bit turn fraction
    assign mech_frac = 16'(count_reg[PULSES_PER_REV_LOG2-1:0]) << AngShift;
    assign elec_frac = 16'(prod[PULSES_PER_REV_LOG2-1:0]) << AngShift;

    // filter sum: a*raw + 2^14 already in acc_reg, b*old in the product
    assign filt_sum = 44'(acc_reg) + 44'(prod);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_fire) state_next = ST_ANGLE;
            ST_ANGLE:   state_next = ST_DIFF;
            ST_DIFF:    state_next = do_update ? ST_RAW : ST_ELEC;
            ST_RAW:     state_next = ST_RAW_SAT;
            ST_RAW_SAT: state_next = ST_ACC_NEW;
            ST_ACC_NEW: state_next = ST_ACC_OLD;
            ST_ACC_OLD: state_next = ST_FILT;
            ST_FILT:    state_next = ST_ELEC;
            ST_ELEC:    state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // multiplier operand selection per step
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_ANGLE:
            begin
                // count times pole pairs, low bits give the electrical angle
                mul_en = 1'b1;
                mul_a  = signed'({9'd0, count_reg});
                mul_b  = signed'({11'd0, cfg.pole_pairs});
            end
            ST_RAW:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(d_reg);
                mul_b  = signed'({2'b00, cfg.speed_scale});
            end
            ST_ACC_NEW:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(raw_reg);
                mul_b  = signed'({2'b00, cfg.filter_gain_new});
            end
            ST_ACC_OLD:
            begin
                mul_en = 1'b1;
                mul_a  = 25'(filt_reg);
                mul_b  = signed'({2'b00, cfg.filter_gain_old});
            end
            ST_ELEC:
            begin
                // at most 2^23 * 127 in magnitude, always fits 32 bits
                mul_en = 1'b1;
                mul_a  = 25'(filt_reg);
                mul_b  = signed'({11'd0, cfg.pole_pairs});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // control and speed state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_count_reg <= '0;
            tick_reg       <= '0;
            filt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIFF)
            begin
                if (do_update)
                begin
                    tick_reg       <= '0;
                    last_count_reg <= count_reg;
                end
                else
                begin
                    tick_reg <= tick_inc;
                end
            end
            if (state_reg == ST_FILT)
                filt_reg <= sat_s24(filt_sum >>> 15);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // per-beat payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
            count_reg <= s_tdata;
        if (state_reg == ST_DIFF)
        begin
            elec_ang_reg <= elec_frac;
            d_reg        <= d_wrap;
            upd_reg      <= do_update;
        end
        if (state_reg == ST_RAW_SAT)
            raw_reg <= sat_s24(44'(prod) >>> 8);
        if (state_reg == ST_ACC_OLD)
            acc_reg <= prod + 43'sd16384;
        if (out_load)
        begin
            out_data_reg <= {prod[31:0], filt_reg, elec_ang_reg, mech_frac};
            out_upd_reg  <= upd_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_upd_reg;

endmodule

@@ hdl/eas_cfg.sv @@
// configuration register file of the encoder angle and speed estimator
module eas_cfg
    import eas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output eas_cfg_t              cfg
);

    eas_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pole_pairs       <= 7'd1;
            cfg_reg.counter_period   <= 16'd4096;
            cfg_reg.wrap_threshold   <= 15'd2048;
            cfg_reg.speed_scale      <= 16'd256;
            cfg_reg.filter_gain_new  <= 16'd3277;
            cfg_reg.filter_gain_old  <= 16'd29491;
            cfg_reg.speed_decimation <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (eas_reg_idx_t'(cfg_idx))
                REG_POLE_PAIRS:  cfg_reg.pole_pairs       <= cfg_data[6:0];
                REG_COUNTER_PER: cfg_reg.counter_period   <= cfg_data;
                REG_WRAP_THRESH: cfg_reg.wrap_threshold   <= cfg_data[14:0];
                REG_SPEED_SCALE: cfg_reg.speed_scale      <= cfg_data;
                REG_GAIN_NEW:    cfg_reg.filter_gain_new  <= cfg_data;
                REG_GAIN_OLD:    cfg_reg.filter_gain_old  <= cfg_data;
                REG_SPEED_DECIM: cfg_reg.speed_decimation <= cfg_data[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/eas_mul.sv @@
// shared signed multiplier with registered product
module eas_mul
    import eas_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [24:0] a,
    input  logic signed [17:0] b,
    output logic signed [42:0] prod
);

    logic signed [42:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= 43'(a) * 43'(b);
    end

    assign prod = prod_reg;

endmodule

@@ hdl/eas_checker.sv @@
// port-level checker of the encoder angle and speed estimator, bound to the top level
`include "assert_macros.svh"

module eas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // one beat in flight: the sequencer is busy right after an accept
    `EAS_ASSERT(a_busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready, "input accepted while sequencer busy")

    // a pending result is held until taken
    `EAS_ASSERT(a_result_held, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "pending result changed")

    // electrical speed is mechanical speed times a non-negative count
    `EAS_ASSERT(a_speed_sign, clk, rst_n, (m_tvalid && m_tdata[87]) |-> m_tdata[55], "electrical speed negative with mechanical speed not negative")

    // an edge seen in reset leaves no result showing on the next edge
    `EAS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid, "result valid right after reset")

endmodule

bind encoder_angle_speed_estimator_core eas_checker u_eas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the encoder angle and speed estimator core
`timescale 1ns / 100ps

module tb_top;
    import eas_pkg::*;

    localparam int PPR_LOG2       = PPR_LOG2_DEFAULT;
    localparam int HALF_PERIOD    = 2;
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLDOFF_CYCLES = 400;   // long receiver stall, fills the block
    localparam int SETTLE_CYCLES  = 20;    // longer than a beat with a speed update takes
    localparam int IDLE_LIMIT     = 5000;  // cycles with no beat and no write

    localparam longint SPD_MAX  = (longint'(1) <<< 23) - 1;
    localparam longint SPD_MIN  = -(longint'(1) <<< 23);
    localparam longint ELEC_MAX = (longint'(1) <<< 31) - 1;
    localparam longint ELEC_MIN = -(longint'(1) <<< 31);

    // one expected result beat
    typedef struct packed {
        logic [15:0]        mech_angle;
        logic [15:0]        elec_angle;
        logic signed [23:0] mech_speed;
        logic signed [31:0] elec_speed;
        logic               speed_updated;
    } estimate_t;

    // mirror of the configuration and speed state, plus the queue of expected estimates
    class estimate_tracker;
        longint pole_pairs;
        longint counter_period;
        longint wrap_threshold;
        longint speed_scale;
        longint gain_new;
        longint gain_old;
        longint decimation;
        logic [15:0] last_count;
        longint      filtered;
        logic [7:0]  ticks;
        estimate_t   expected_q[$];
        int          errors;

        function new();
            pole_pairs     = 1;
            counter_period = 4096;
            wrap_threshold = 2048;
            speed_scale    = 256;
            gain_new       = 3277;
            gain_old       = 29491;
            decimation     = 4;
            last_count     = '0;
            filtered       = 0;
            ticks          = '0;
            errors         = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // count modulo pulses per turn, scaled to a 16-bit fraction of a turn
        function logic [15:0] turn_fraction(logic [31:0] c);
            logic [31:0] frac;
            frac = (c & ((32'd1 << PPR_LOG2) - 32'd1)) << (16 - PPR_LOG2);
            return frac[15:0];
        endfunction

        function void write_reg(eas_reg_idx_t idx, logic [15:0] val);
            case (idx)
                REG_POLE_PAIRS:  pole_pairs     = longint'(val[6:0]);
                REG_COUNTER_PER: counter_period = longint'(val);
                REG_WRAP_THRESH: wrap_threshold = longint'(val[14:0]);
                REG_SPEED_SCALE: speed_scale    = longint'(val);
                REG_GAIN_NEW:    gain_new       = longint'(val);
                REG_GAIN_OLD:    gain_old       = longint'(val);
                REG_SPEED_DECIM: decimation     = longint'(val[7:0]);
                default: ;
            endcase
        endfunction

        // one control tick: angles always, speed every decimation-th tick
        function void note_count(logic [15:0] count);
            estimate_t   e;
            logic [15:0] delta;
            longint      d;
            longint      raw;
            longint      acc;
            e.mech_angle    = turn_fraction({16'd0, count});
            e.elec_angle    = turn_fraction(32'(count) * 32'(pole_pairs));
            e.speed_updated = 1'b0;
            ticks = ticks + 8'd1;
            if (longint'(ticks) >= decimation) begin
                ticks      = '0;
                delta      = count - last_count;
                last_count = count;
                d = longint'($signed(delta));
                if (d > wrap_threshold)
                    d = d - counter_period;
                else if (d < -wrap_threshold)
                    d = d + counter_period;
                raw = clamp((d * speed_scale) >>> 8, SPD_MIN, SPD_MAX);
                acc = gain_new * raw + gain_old * filtered + (longint'(1) <<< 14);
                filtered = clamp(acc >>> 15, SPD_MIN, SPD_MAX);
                e.speed_updated = 1'b1;
            end
            e.mech_speed = 24'(filtered);
            e.elec_speed = 32'(clamp(filtered * pole_pairs, ELEC_MIN, ELEC_MAX));
            expected_q.push_back(e);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_beat(logic [87:0] data, logic updated);
            estimate_t e;
            if (expected_q.size() == 0) begin
                $error("result beat with no estimate pending: tdata %h", data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("mech_angle", e.mech_angle, data[15:0]);
            compare_field("elec_angle", e.elec_angle, data[31:16]);
            compare_field("mech_speed", e.mech_speed, $signed(data[55:32]));
            compare_field("elec_speed", e.elec_speed, $signed(data[87:56]));
            compare_field("speed_updated", e.speed_updated, updated);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [87:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    estimate_tracker tracker = new();
    int  burst_left    = 0;
    int  quiet_cycles  = 0;
    bit  hold_off_req  = 1'b0;

    encoder_angle_speed_estimator_core #(
        .PULSES_PER_REV_LOG2 (PPR_LOG2)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // offer one encoder count; bursts of back-to-back beats separated by random gaps.
    // tvalid stays high across a burst, so it is never dropped and raised in one step
    task automatic send_count(input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_count(value);
        burst_left--;
    endtask

    // one register write; the caller lowers cfg_we after the last one
    task automatic write_one(input eas_reg_idx_t idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
    endtask

    task automatic apply_settings(input logic [15:0] pp, input logic [15:0] period,
                                  input logic [15:0] thresh, input logic [15:0] scale,
                                  input logic [15:0] g_new, input logic [15:0] g_old,
                                  input logic [15:0] decim);
        write_one(REG_POLE_PAIRS, pp);
        write_one(REG_COUNTER_PER, period);
        write_one(REG_WRAP_THRESH, thresh);
        write_one(REG_SPEED_SCALE, scale);
        write_one(REG_GAIN_NEW, g_new);
        write_one(REG_GAIN_OLD, g_old);
        write_one(REG_SPEED_DECIM, decim);
        cfg_we <= 1'b0;
    endtask

    // mostly sensible settings, now and then raw 16-bit values (upper bits get dropped)
    task automatic random_settings(input bit slow_updates);
        logic [15:0] pp;
        logic [15:0] period;
        logic [15:0] thresh;
        logic [15:0] g_new;
        logic [15:0] g_old;
        logic [15:0] decim;
        pp     = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
        period = ($urandom_range(0, 2) == 0) ? 16'(1 << PPR_LOG2) : 16'($urandom);
        thresh = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
        g_new  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        // a well-formed filter has weights summing to one
        g_old  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(32768 - g_new[15:0]);
        if (slow_updates)
            decim = 16'd255;
        else if ($urandom_range(0, 7) == 0)
            decim = 16'($urandom);
        else
            decim = 16'($urandom_range(0, 8));
        apply_settings(pp, period, thresh, 16'($urandom), g_new, g_old, decim);
    endtask

    // hold the sender until every estimate is back, then let the core settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random ready patterns, full-speed stretches, and a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= mode_left[1];
                endcase
            end
        end
    end

    // result side: every accepted beat is checked against the oldest estimate
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_beat(m_tdata, m_tuser[0]);
    end

    // watchdog on progress: any beat or write resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("** encoder_angle_speed_estimator_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        // reset settings: decimation 4, threshold 2048, period 4096
        logic [15:0] reset_seq [10] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h0800,
                                        16'h1000, 16'h2000, 16'h3000, 16'h8801,
                                        16'h7FFF, 16'h0001};
        // extremes with gains of one each and decimation 1: big jumps, saturation
        logic [15:0] max_seq [8]    = '{16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF,
                                        16'h7FFF, 16'hFFFF, 16'h7FFE, 16'hFFFF};
        logic [15:0] zero_seq [3]   = '{16'hFFFF, 16'h8000, 16'h0000};
        logic [15:0] wide_seq [4]   = '{16'h7FFF, 16'hFFFF, 16'h8001, 16'h0FFF};
        logic [15:0] pos;
        int          vel;
        int          vmax;
        int          phase;
        int          len;
        int          random_sent;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_POLE_PAIRS;
        cfg_data = '0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_seq[i])
            send_count(reset_seq[i]);
        drain();

        // largest period, threshold and scale, 64 pole pairs, gains of one each so the filter runs away
        apply_settings(16'd64, 16'd65535, 16'd32767, 16'd65535, 16'd32768, 16'd32768, 16'd1);
        foreach (max_seq[i])
            send_count(max_seq[i]);
        drain();

        // zero pole pairs, zero period, zero decimation (update every tick), all zero
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        foreach (zero_seq[i])
            send_count(zero_seq[i]);
        drain();

        // widest pole-pair field, new-sample gain near two and old-sample gain of one
        apply_settings(16'd127, 16'd4096, 16'd100, 16'd65535, 16'd65535, 16'd32768, 16'd0);
        foreach (wide_seq[i])
            send_count(wide_seq[i]);
        drain();

        // random part: mostly a shaft turning at a steady rate with jitter,
        // with the odd jump in count and change of rate
        random_sent = 0;
        phase       = 0;
        pos         = 16'($urandom);
        vel         = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            random_settings(phase == 1);
            if (phase == 2)
                hold_off_req = 1'b1;
            len  = (phase == 1) ? 260 : $urandom_range(40, 90);
            vmax = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 600);
            vel  = int'($urandom_range(0, 2 * vmax)) - vmax;
            for (int n = 0; n < len; n++) begin
                if ($urandom_range(0, 19) == 0)
                    pos = 16'($urandom);
                if ($urandom_range(0, 29) == 0)
                    vel = int'($urandom_range(0, 2 * vmax)) - vmax;
                pos = pos + 16'(vel + int'($urandom_range(0, 4)) - 2);
                send_count(pos);
                random_sent++;
            end
            drain();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("** encoder_angle_speed_estimator_core: PASSED **");
        else
            $display("** encoder_angle_speed_estimator_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/eas_pkg.sv
hdl/eas_cfg.sv
hdl/eas_mul.sv
hdl/encoder_angle_speed_estimator_core.sv
hdl/eas_checker.sv
tb/sv/tb_top.sv
